// ===== rtl/spbc_pkg.sv =====
// shared types, constants and helpers of the soft power button controller
`timescale 1ns / 1ps

package spbc_pkg;

   // timer width, all ms timers saturate at 2^TIMER_BITS - 1
   localparam int TIMER_BITS = 16;
   localparam int CFG_BITS   = 16;
   localparam int HELD_BITS  = 16;
   localparam int BLINK_BITS = 5;
   localparam int PULSE_BITS = 7;
   localparam int INDEX_BITS = 3;

   localparam logic [TIMER_BITS-1:0] BLINK_STEP_MS = TIMER_BITS'(100);
   localparam logic [TIMER_BITS-1:0] FLASH_STEP_MS = TIMER_BITS'(50);
   localparam logic [TIMER_BITS-1:0] HOLD_MS       = TIMER_BITS'(1100);
   localparam logic [TIMER_BITS-1:0] OFF_TOGGLE_MS = TIMER_BITS'(200);
   localparam logic [BLINK_BITS-1:0] READY_STEPS   = BLINK_BITS'(7);
   localparam logic [BLINK_BITS-1:0] FLASH_STEPS   = BLINK_BITS'(20);
   localparam logic [PULSE_BITS-1:0] ACT_PULSE_MS  = PULSE_BITS'(50);
   localparam logic [PULSE_BITS-1:0] HB_PULSE_MS   = PULSE_BITS'(100);

   localparam logic [CFG_BITS-1:0] LATCH_DELAY_RST = CFG_BITS'(500);
   localparam logic [CFG_BITS-1:0] LONG_PRESS_RST  = CFG_BITS'(2000);
   localparam logic [CFG_BITS-1:0] HB_PERIOD_RST   = CFG_BITS'(3000);
   localparam logic [CFG_BITS-1:0] WARN_START_RST  = CFG_BITS'(1000);
   localparam logic [CFG_BITS-1:0] WARN_END_RST    = CFG_BITS'(1100);

   // register indexes of the configuration port
   localparam logic [INDEX_BITS-1:0] CSR_LATCH_DELAY = INDEX_BITS'(0);
   localparam logic [INDEX_BITS-1:0] CSR_LONG_PRESS  = INDEX_BITS'(1);
   localparam logic [INDEX_BITS-1:0] CSR_HB_PERIOD   = INDEX_BITS'(2);
   localparam logic [INDEX_BITS-1:0] CSR_WARN_START  = INDEX_BITS'(3);
   localparam logic [INDEX_BITS-1:0] CSR_WARN_END    = INDEX_BITS'(4);

   typedef enum logic [2:0] {
      PH_BOOT  = 3'd0,
      PH_BLINK = 3'd1,
      PH_RUN   = 3'd2,
      PH_FLASH = 3'd3,
      PH_HOLD  = 3'd4,
      PH_OFF   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] latch_delay_ms;
      logic [CFG_BITS-1:0] long_press_ms;
      logic [CFG_BITS-1:0] heartbeat_period_ms;
      logic [CFG_BITS-1:0] warn_start_ms;
      logic [CFG_BITS-1:0] warn_end_ms;
   } cfg_type;

   typedef struct packed {
      phase_type               phase;
      logic [TIMER_BITS-1:0]   phase_timer;
      logic [BLINK_BITS-1:0]   blink_count;
      logic                    press_active;
      logic [TIMER_BITS-1:0]   press_timer;
      logic [TIMER_BITS-1:0]   hb_timer;
      logic [PULSE_BITS-1:0]   act_pulse;
      logic [PULSE_BITS-1:0]   hb_pulse;
      logic                    latch;
      logic                    warn;
      logic                    hb;
      logic                    act;
   } state_type;

   typedef struct packed {
      logic                  latch_on;
      logic                  led_warning;
      logic                  led_heartbeat;
      logic                  led_activity;
      logic [2:0]            phase;
      logic                  release_valid;
      logic [HELD_BITS-1:0]  held_ms;
   } result_type;

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
      return (v == '1) ? v : v + TIMER_BITS'(1);
   endfunction

endpackage

// ===== rtl/spbc_csr.sv =====
// configuration registers of the soft power button controller
`timescale 1ns / 1ps

module spbc_csr
   import spbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]   csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LATCH_DELAY: cfg_in.latch_delay_ms      = csr_wdata;
            CSR_LONG_PRESS:  cfg_in.long_press_ms       = csr_wdata;
            CSR_HB_PERIOD:   cfg_in.heartbeat_period_ms = csr_wdata;
            CSR_WARN_START:  cfg_in.warn_start_ms       = csr_wdata;
            CSR_WARN_END:    cfg_in.warn_end_ms         = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.latch_delay_ms      <= LATCH_DELAY_RST;
         cfg_ff.long_press_ms       <= LONG_PRESS_RST;
         cfg_ff.heartbeat_period_ms <= HB_PERIOD_RST;
         cfg_ff.warn_start_ms       <= WARN_START_RST;
         cfg_ff.warn_end_ms         <= WARN_END_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/spbc_step.sv =====
// next-state and result logic for one millisecond tick
`timescale 1ns / 1ps

module spbc_step
   import spbc_pkg::*;
(
   input  state_type  cur,
   input  cfg_type    cfg,
   input  logic       sense_n,
   input  logic       alt_sense_n,
   output state_type  nxt,
   output result_type res
);

   logic                  pressed;
   logic                  release_valid;
   logic [HELD_BITS-1:0]  held_ms;
   logic [31:0]           press_wide;
   logic [TIMER_BITS-1:0] t_inc;
   logic                  shutdown;

   assign pressed = !sense_n || !alt_sense_n;

   always_comb begin
      nxt           = cur;
      release_valid = 1'b0;
      held_ms       = '0;
      press_wide    = '0;
      shutdown      = 1'b0;
      t_inc         = sat_inc(cur.phase_timer);

      unique case (cur.phase)
         PH_BOOT: begin
            if (cur.phase_timer >= cfg.latch_delay_ms) begin
               nxt.phase       = PH_BLINK;
               nxt.phase_timer = '0;
               nxt.blink_count = '0;
               nxt.latch       = 1'b1;
               nxt.warn        = 1'b0;
               nxt.hb          = 1'b0;
               nxt.act         = 1'b0;
            end else begin
               nxt.phase_timer = t_inc;
            end
         end
         PH_BLINK: begin
            nxt.phase_timer = t_inc;
            if (t_inc >= BLINK_STEP_MS) begin
               nxt.phase_timer = '0;
               nxt.blink_count = cur.blink_count + BLINK_BITS'(1);
            end
            nxt.latch = 1'b1;
            nxt.warn  = 1'b0;
            nxt.hb    = 1'b0;
            if (nxt.blink_count >= READY_STEPS) begin
               nxt.phase        = PH_RUN;
               nxt.blink_count  = '0;
               nxt.hb_timer     = '0;
               nxt.press_active = 1'b0;
               nxt.press_timer  = '0;
               nxt.act_pulse    = '0;
               nxt.hb_pulse     = '0;
               nxt.act          = 1'b0;
            end else begin
               nxt.act = nxt.blink_count[0];
            end
         end
         PH_RUN: begin
            // pulses count down, a press in progress counts up
            if (cur.act_pulse != '0) nxt.act_pulse = cur.act_pulse - PULSE_BITS'(1);
            if (cur.hb_pulse != '0)  nxt.hb_pulse  = cur.hb_pulse - PULSE_BITS'(1);
            if (cur.press_active)    nxt.press_timer = sat_inc(cur.press_timer);
            if (pressed && !cur.press_active) begin
               nxt.press_active = 1'b1;
               nxt.press_timer  = '0;
               nxt.act_pulse    = ACT_PULSE_MS;
            end
            if (pressed) begin
               if (nxt.press_timer > cfg.warn_start_ms &&
                   nxt.press_timer < cfg.warn_end_ms) begin
                  nxt.warn = 1'b1;
               end
               if (nxt.press_timer >= cfg.long_press_ms) begin
                  shutdown = 1'b1;
               end
            end else if (cur.press_active) begin
               nxt.press_active = 1'b0;
               nxt.warn         = 1'b0;
               release_valid    = 1'b1;
               press_wide       = 32'(nxt.press_timer);
               held_ms          = (press_wide > 32'hFFFF) ? '1 : press_wide[HELD_BITS-1:0];
            end
            if (shutdown) begin
               nxt.phase        = PH_FLASH;
               nxt.phase_timer  = '0;
               nxt.blink_count  = '0;
               nxt.press_active = 1'b0;
               nxt.act_pulse    = '0;
               nxt.hb_pulse     = '0;
               nxt.latch        = 1'b1;
               nxt.warn         = 1'b1;
               nxt.hb           = 1'b0;
               nxt.act          = 1'b0;
            end else begin
               nxt.hb_timer = sat_inc(cur.hb_timer);
               if (nxt.hb_timer >= cfg.heartbeat_period_ms) begin
                  nxt.hb_timer = '0;
                  nxt.hb_pulse = HB_PULSE_MS;
               end
               nxt.latch = 1'b1;
               nxt.hb    = (nxt.hb_pulse != '0);
               nxt.act   = (nxt.act_pulse != '0);
            end
         end
         PH_FLASH: begin
            nxt.phase_timer = t_inc;
            if (t_inc >= FLASH_STEP_MS) begin
               nxt.phase_timer = '0;
               nxt.blink_count = cur.blink_count + BLINK_BITS'(1);
            end
            nxt.latch = 1'b1;
            if (nxt.blink_count >= FLASH_STEPS) begin
               nxt.phase       = PH_HOLD;
               nxt.phase_timer = '0;
               nxt.blink_count = '0;
               nxt.warn        = 1'b1;
               nxt.hb          = 1'b1;
               nxt.act         = 1'b1;
            end else begin
               nxt.warn = !nxt.blink_count[0];
               nxt.hb   = 1'b0;
               nxt.act  = 1'b0;
            end
         end
         PH_HOLD: begin
            nxt.phase_timer = t_inc;
            if (t_inc >= HOLD_MS) begin
               nxt.phase       = PH_OFF;
               nxt.phase_timer = '0;
               nxt.latch       = 1'b0;
               nxt.warn        = 1'b0;
               nxt.hb          = 1'b1;
               nxt.act         = 1'b1;
            end
         end
         default: begin
            // unlatched, warning toggles forever
            nxt.phase       = PH_OFF;
            nxt.phase_timer = t_inc;
            if (t_inc >= OFF_TOGGLE_MS) begin
               nxt.phase_timer = '0;
               nxt.warn        = !cur.warn;
            end
         end
      endcase
   end

   always_comb begin
      res.latch_on      = nxt.latch;
      res.led_warning   = nxt.warn;
      res.led_heartbeat = nxt.hb;
      res.led_activity  = nxt.act;
      res.phase         = nxt.phase;
      res.release_valid = release_valid;
      res.held_ms       = held_ms;
   end

endmodule

// ===== rtl/soft_power_button_controller_unit.sv =====
// top level of the long-press soft power button controller
`timescale 1ns / 1ps

// usage
// - req channel: one transfer per millisecond tick, carrying the two active-low
//   button sense bits (req_sense_n, req_alt_sense_n); pressed if either is low
// - rsp channel: exactly one result per tick, the LED and latch levels, the
//   phase and, on the tick a press ends in run mode, release_valid and held_ms
// - csr port: plain write, csr_we with csr_index and csr_wdata, no wait states;
//   write only while the block is idle; unknown indexes are dropped
// - result: the result of a transferred tick is held in the result register
// - throughput: one tick per cycle while no result waits on rsp_ready; the
//   state update and the result are formed combinationally by the step logic
//   between the state registers and the result register
// - stall: while a result waits, req_ready follows rsp_ready, so a new tick
//   is taken in the same cycle the waiting result is transferred
// - reset: boot wait phase, all LEDs on, latch off, timers zero, config
//   registers back to their defaults, no result pending
module soft_power_button_controller_unit
   import spbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // tick input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_sense_n,
   input  logic                  req_alt_sense_n,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_latch_on,
   output logic                  rsp_led_warning,
   output logic                  rsp_led_heartbeat,
   output logic                  rsp_led_activity,
   output logic [2:0]            rsp_phase,
   output logic                  rsp_release_valid,
   output logic [HELD_BITS-1:0]  rsp_held_ms,
   // configuration writes
   input  logic                  csr_we,
   input  logic [INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]   csr_wdata
);

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   result_type res_in;
   result_type res_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;

   spbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spbc_step u_step (
      .cur         (state_ff),
      .cfg         (cfg),
      .sense_n     (req_sense_n),
      .alt_sense_n (req_alt_sense_n),
      .nxt         (state_in),
      .res         (res_in)
   );

   // the result register frees up in the same cycle its result is taken
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // control state and tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff          <= 1'b0;
         state_ff.phase        <= PH_BOOT;
         state_ff.phase_timer  <= '0;
         state_ff.blink_count  <= '0;
         state_ff.press_active <= 1'b0;
         state_ff.press_timer  <= '0;
         state_ff.hb_timer     <= '0;
         state_ff.act_pulse    <= '0;
         state_ff.hb_pulse     <= '0;
         state_ff.latch        <= 1'b0;
         state_ff.warn         <= 1'b1;
         state_ff.hb           <= 1'b1;
         state_ff.act          <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   // result payload, loaded on every accepted tick
   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_latch_on      = res_ff.latch_on;
   assign rsp_led_warning   = res_ff.led_warning;
   assign rsp_led_heartbeat = res_ff.led_heartbeat;
   assign rsp_led_activity  = res_ff.led_activity;
   assign rsp_phase         = res_ff.phase;
   assign rsp_release_valid = res_ff.release_valid;
   assign rsp_held_ms       = res_ff.held_ms;

endmodule
